// File: hdl/tga_rle_pixel_decoder_assert.svh
// tga_rle_pixel_decoder_assert.svh
// assertion macros for the run-length image decoder; the using module
// must have clk_i and rst_ni in scope
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication
`define TGARLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGARLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tgarle_pkg.sv
// tgarle_pkg.sv
// shared constants, codes and types of the run-length image decoder
// no dependencies
package tgarle_pkg;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned PIX_W      = $clog2(MAX_PIXELS + 1);
  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned HDR_CNT_W  = 5;
  localparam int unsigned AREA_W     = 32;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // header byte positions
  localparam logic [HDR_CNT_W-1:0] HB_ID_LEN    = 5'd0;
  localparam logic [HDR_CNT_W-1:0] HB_CMAP_TYPE = 5'd1;
  localparam logic [HDR_CNT_W-1:0] HB_IMG_TYPE  = 5'd2;
  localparam logic [HDR_CNT_W-1:0] HB_ORG_FIRST = 5'd8;
  localparam logic [HDR_CNT_W-1:0] HB_ORG_LAST  = 5'd11;
  localparam logic [HDR_CNT_W-1:0] HB_WIDTH_LO  = 5'd12;
  localparam logic [HDR_CNT_W-1:0] HB_WIDTH_HI  = 5'd13;
  localparam logic [HDR_CNT_W-1:0] HB_HEIGHT_LO = 5'd14;
  localparam logic [HDR_CNT_W-1:0] HB_HEIGHT_HI = 5'd15;
  localparam logic [HDR_CNT_W-1:0] HB_DEPTH     = 5'd16;
  localparam logic [HDR_CNT_W-1:0] HB_DESC      = 5'd17;

  localparam logic [7:0] IMG_TYPE_RLE   = 8'd10;
  localparam logic [7:0] DEPTH_24       = 8'd24;
  localparam logic [7:0] DEPTH_32       = 8'd32;
  localparam logic [7:0] RUN_LEN_MASK   = 8'h7f;
  localparam int unsigned DESC_BOTTOM_UP_BIT = 3;
  localparam int unsigned PKT_RUN_BIT        = 7;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [2:0] {
    ERR_ID          = 3'd0,
    ERR_PALETTE     = 3'd1,
    ERR_IMG_TYPE    = 3'd2,
    ERR_ORIGIN      = 3'd3,
    ERR_DEPTH       = 3'd4,
    ERR_TOO_LARGE   = 3'd5,
    ERR_BYTE_IN_RUN = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_HEADER    = 6'b000010,
    ST_CTRL      = 6'b000100,
    ST_RAW       = 6'b001000,
    ST_RUN_COLOR = 6'b010000,
    ST_RUN_PEND  = 6'b100000
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } q_entry_t;

  // front to queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // queue head to back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// File: hdl/tgarle_front.sv
// tgarle_front.sv
// input side: takes stream items and sorts them into byte, start and tick commands
// depends on tgarle_pkg
module tgarle_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tgarle_pkg::IN_DATA_W-1:0] s_axis_tdata,  // data_byte
  input  logic [tgarle_pkg::IN_USER_W-1:0] s_axis_tuser,  // [0] op, [1] start_req
  input  logic                             q_full_i,
  output tgarle_pkg::q_push_t              q_push_o
);
  import tgarle_pkg::*;

  logic op_tick;
  logic start_req;

  assign op_tick   = s_axis_tuser[0];
  assign start_req = s_axis_tuser[1];

  assign s_axis_tready = !q_full_i;

  always_comb begin
    q_push_o.push       = s_axis_tvalid && !q_full_i;
    q_push_o.entry.data = s_axis_tdata;
    // start_req means nothing on a tick
    if (op_tick) begin
      q_push_o.entry.cmd = CMD_TICK;
    end else if (start_req) begin
      q_push_o.entry.cmd = CMD_START;
    end else begin
      q_push_o.entry.cmd = CMD_BYTE;
    end
  end

endmodule

// File: hdl/tgarle_fifo.sv
// tgarle_fifo.sv
// short command queue between the input side and the decode back end
// depends on tgarle_pkg
module tgarle_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tgarle_pkg::q_push_t q_push_i,
  input  logic                pop_i,
  output logic                full_o,
  output tgarle_pkg::q_head_t q_head_o
);
  import tgarle_pkg::*;

  q_entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q, wptr_d;
  logic [FIFO_AW-1:0]   rptr_q, rptr_d;
  logic [FIFO_AW:0]     count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o         = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign q_head_o.valid = (count_q != '0);
  assign q_head_o.entry = mem_q[rptr_q];

  assign do_push = q_push_i.push && !full_o;
  assign do_pop  = pop_i && q_head_o.valid;

  always_comb begin
    wptr_d  = do_push ? wptr_q + FIFO_AW'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + FIFO_AW'(1) : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= q_push_i.entry;
    end
  end

endmodule

// File: hdl/tgarle_back.sv
// tgarle_back.sv
// decode back end: header checks, packet decode, pixel addressing, output register
// depends on tgarle_pkg and tga_rle_pixel_decoder_assert.svh
`include "tga_rle_pixel_decoder_assert.svh"

module tgarle_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tgarle_pkg::q_head_t               q_head_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tgarle_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // address, red, green,
                                                           // blue, alpha, error_code
  output logic [tgarle_pkg::OUT_USER_W-1:0] m_axis_tuser,  // kind
  output logic                              m_axis_tlast   // last_pixel
);
  import tgarle_pkg::*;

  // decode state
  state_e                state_q, state_d;
  logic [HDR_CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0]           width_q, width_d;
  logic [15:0]           height_q, height_d;
  logic [AREA_W-1:0]     area_q, area_d;
  logic                  four_q, four_d;
  logic [7:0]            pkt_left_q, pkt_left_d;
  logic [1:0]            col_idx_q, col_idx_d;
  logic [7:0]            color_q [4];
  logic [ADDR_W-1:0]     waddr_q, waddr_d;
  logic [ADDR_W-1:0]     wrap_step_q, wrap_step_d;
  logic [15:0]           row_col_q, row_col_d;
  logic [PIX_W-1:0]      pix_left_q, pix_left_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  out_kind_q;
  logic [ADDR_W-1:0]     out_addr_q;
  logic [7:0]            out_red_q, out_green_q, out_blue_q, out_alpha_q;
  logic                  out_last_q;
  logic [2:0]            out_err_q;

  // per-item result
  logic                  res_valid;
  logic                  res_kind;
  logic [ADDR_W-1:0]     res_addr;
  logic [7:0]            res_red, res_green, res_blue, res_alpha;
  logic                  res_last;
  logic [2:0]            res_err;

  state_e                state_eff;
  logic [HDR_CNT_W-1:0]  hdr_n;
  logic [7:0]            byte_in;
  logic                  col_we;
  logic                  emit;
  logic [7:0]            col [4];
  logic [AREA_W-1:0]     area_mul;
  logic [ADDR_W-1:0]     comps;
  logic [ADDR_W-1:0]     start_base;
  logic [ADDR_W-1:0]     row_bytes;
  logic                  bot_up;
  logic                  row_wrap;
  logic [PIX_W-1:0]      pix_next;
  logic [7:0]            pkt_next;
  logic [1:0]            last_idx;

  assign pop_o     = q_head_i.valid && (!out_valid_q || m_axis_tready);
  assign byte_in   = q_head_i.entry.data;
  assign state_eff = (q_head_i.entry.cmd == CMD_START) ? ST_HEADER : state_q;
  assign hdr_n     = (q_head_i.entry.cmd == CMD_START) ? '0 : hdr_cnt_q;

  assign comps    = four_q ? ADDR_W'(4) : ADDR_W'(3);
  assign last_idx = four_q ? 2'd3 : 2'd2;
  assign area_mul = {16'b0, width_q} * {16'b0, height_q};
  assign bot_up   = byte_in[DESC_BOTTOM_UP_BIT];
  assign start_base = area_q[ADDR_W-1:0] - ADDR_W'(width_q);
  assign row_bytes  = four_q ? ADDR_W'({width_q, 2'b00})
                             : ADDR_W'({width_q, 1'b0}) + ADDR_W'(width_q);
  assign row_wrap = ({1'b0, row_col_q} + 17'd1) == {1'b0, width_q};
  assign pix_next = (pix_left_q != '0) ? pix_left_q - PIX_W'(1) : '0;
  assign pkt_next = (pkt_left_q != '0) ? pkt_left_q - 8'd1 : '0;

  // colour bytes with the byte arriving now folded in
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      col[i] = (col_we && (col_idx_q == 2'(i))) ? byte_in : color_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    hdr_cnt_d   = hdr_cnt_q;
    width_d     = width_q;
    height_d    = height_q;
    area_d      = area_q;
    four_d      = four_q;
    pkt_left_d  = pkt_left_q;
    col_idx_d   = col_idx_q;
    waddr_d     = waddr_q;
    wrap_step_d = wrap_step_q;
    row_col_d   = row_col_q;
    pix_left_d  = pix_left_q;
    res_valid   = 1'b0;
    res_kind    = KIND_PIXEL;
    res_addr    = '0;
    res_red     = '0;
    res_green   = '0;
    res_blue    = '0;
    res_alpha   = '0;
    res_last    = 1'b0;
    res_err     = '0;
    col_we      = 1'b0;
    emit        = 1'b0;

    if (pop_o) begin
      if (q_head_i.entry.cmd == CMD_TICK) begin
        emit = (state_q == ST_RUN_PEND);
      end else begin
        case (state_eff)
          ST_HEADER: begin
            state_d   = ST_HEADER;
            hdr_cnt_d = hdr_n + HDR_CNT_W'(1);
            if (hdr_n == HB_ID_LEN && byte_in != 8'd0) begin
              res_valid = 1'b1;
              res_err   = ERR_ID;
            end else if (hdr_n == HB_CMAP_TYPE && byte_in != 8'd0) begin
              res_valid = 1'b1;
              res_err   = ERR_PALETTE;
            end else if (hdr_n == HB_IMG_TYPE && byte_in != IMG_TYPE_RLE) begin
              res_valid = 1'b1;
              res_err   = ERR_IMG_TYPE;
            end else if (hdr_n >= HB_ORG_FIRST && hdr_n <= HB_ORG_LAST &&
                         byte_in != 8'd0) begin
              res_valid = 1'b1;
              res_err   = ERR_ORIGIN;
            end else if (hdr_n == HB_WIDTH_LO) begin
              width_d = {8'd0, byte_in};
            end else if (hdr_n == HB_WIDTH_HI) begin
              width_d = {byte_in, width_q[7:0]};
            end else if (hdr_n == HB_HEIGHT_LO) begin
              height_d = {8'd0, byte_in};
            end else if (hdr_n == HB_HEIGHT_HI) begin
              height_d = {byte_in, height_q[7:0]};
            end else if (hdr_n == HB_DEPTH) begin
              area_d = area_mul;
              if (byte_in == DEPTH_24) begin
                four_d = 1'b0;
              end else if (byte_in == DEPTH_32) begin
                four_d = 1'b1;
              end
              if (byte_in != DEPTH_24 && byte_in != DEPTH_32) begin
                res_valid = 1'b1;
                res_err   = ERR_DEPTH;
              end else if (area_mul > AREA_W'(MAX_PIXELS)) begin
                res_valid = 1'b1;
                res_err   = ERR_TOO_LARGE;
              end
            end else if (hdr_n == HB_DESC) begin
              pix_left_d = area_q[PIX_W-1:0];
              row_col_d  = '0;
              pkt_left_d = '0;
              col_idx_d  = '0;
              // bottom-up images start on the last row
              if (bot_up && height_q != 16'd0) begin
                waddr_d = four_q ? {start_base[ADDR_W-3:0], 2'b00}
                                 : start_base + {start_base[ADDR_W-2:0], 1'b0};
              end else begin
                waddr_d = '0;
              end
              wrap_step_d = bot_up ? comps - {row_bytes[ADDR_W-2:0], 1'b0} : comps;
              state_d     = (area_q == '0) ? ST_IDLE : ST_CTRL;
            end
            if (res_valid) begin
              res_kind = KIND_ERROR;
              state_d  = ST_IDLE;
            end
          end
          ST_CTRL: begin
            pkt_left_d = (byte_in & RUN_LEN_MASK) + 8'd1;
            state_d    = byte_in[PKT_RUN_BIT] ? ST_RUN_COLOR : ST_RAW;
            col_idx_d  = '0;
          end
          ST_RAW, ST_RUN_COLOR: begin
            col_we = 1'b1;
            if (col_idx_q == last_idx) begin
              col_idx_d = '0;
              emit      = 1'b1;
            end else begin
              col_idx_d = col_idx_q + 2'd1;
            end
          end
          ST_RUN_PEND: begin
            // byte dropped, run goes on
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_err   = ERR_BYTE_IN_RUN;
          end
          default: begin
          end
        endcase
      end
    end

    if (emit) begin
      res_valid  = 1'b1;
      res_kind   = KIND_PIXEL;
      res_addr   = waddr_q;
      res_red    = col[2];
      res_green  = col[1];
      res_blue   = col[0];
      res_alpha  = four_q ? col[3] : 8'd0;
      res_last   = (pix_next == '0);
      waddr_d    = waddr_q + (row_wrap ? wrap_step_q : comps);
      row_col_d  = row_wrap ? 16'd0 : row_col_q + 16'd1;
      pix_left_d = pix_next;
      pkt_left_d = pkt_next;
      if (pix_next == '0) begin
        state_d    = ST_IDLE;
        pkt_left_d = '0;
      end else if (pkt_next == '0) begin
        state_d = ST_CTRL;
      end else if (state_eff == ST_RUN_COLOR) begin
        state_d = ST_RUN_PEND;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hdr_cnt_q   <= '0;
      width_q     <= '0;
      height_q    <= '0;
      area_q      <= '0;
      four_q      <= 1'b0;
      pkt_left_q  <= '0;
      col_idx_q   <= '0;
      waddr_q     <= '0;
      wrap_step_q <= '0;
      row_col_q   <= '0;
      pix_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_cnt_q   <= hdr_cnt_d;
      width_q     <= width_d;
      height_q    <= height_d;
      area_q      <= area_d;
      four_q      <= four_d;
      pkt_left_q  <= pkt_left_d;
      col_idx_q   <= col_idx_d;
      waddr_q     <= waddr_d;
      wrap_step_q <= wrap_step_d;
      row_col_q   <= row_col_d;
      pix_left_q  <= pix_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      color_q[col_idx_q] <= byte_in;
    end
    if (pop_o && res_valid) begin
      out_kind_q  <= res_kind;
      out_addr_q  <= res_addr;
      out_red_q   <= res_red;
      out_green_q <= res_green;
      out_blue_q  <= res_blue;
      out_alpha_q <= res_alpha;
      out_last_q  <= res_last;
      out_err_q   <= res_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_err_q, out_alpha_q, out_blue_q, out_green_q,
                          out_red_q, out_addr_q};

  `TGARLE_ASSERT_IMP(a_pixels_left_live,
    (state_q == ST_CTRL || state_q == ST_RAW || state_q == ST_RUN_COLOR ||
     state_q == ST_RUN_PEND), pix_left_q != '0, "decoding with no pixels left")
  `TGARLE_ASSERT_IMP(a_row_col_in_range,
    (state_q == ST_CTRL || state_q == ST_RAW || state_q == ST_RUN_COLOR ||
     state_q == ST_RUN_PEND), row_col_q < width_q, "row column past image width")
  `TGARLE_ASSERT_IMP(a_packet_left_live,
    (state_q == ST_RAW || state_q == ST_RUN_COLOR || state_q == ST_RUN_PEND),
    pkt_left_q != '0, "packet state with empty packet count")
  `TGARLE_ASSERT_NXT(a_result_registered, (pop_o && res_valid), m_axis_tvalid,
    "result lost on its way to the output register")

endmodule

// File: hdl/tga_rle_pixel_decoder.sv
// Run-length truecolor image decoder. Each input item is one file byte or one run tick;
// an item is taken every cycle while the four-entry command queue has room, and the
// back end retires one queued item per cycle whenever its output register is empty or
// being read, so the sustained rate is one item per clock. With the queue empty, an
// item is first written into the queue and its result is then registered in the
// output register. The header area check uses one 16x16 multiply on the depth byte;
// the start address of a bottom-up image is formed from that product with adds on
// the descriptor byte. Errors stop decoding until the next start byte, except a byte
// that arrives during a pending run, which is reported and dropped.
// depends on tgarle_pkg, tgarle_front, tgarle_fifo, tgarle_back
module tga_rle_pixel_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tgarle_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // data_byte
  input  logic [tgarle_pkg::IN_USER_W-1:0]  s_axis_tuser,   // [0] op, [1] start_req
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tgarle_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [21:0] address,
                                                            // [29:22] red,
                                                            // [37:30] green,
                                                            // [45:38] blue,
                                                            // [53:46] alpha,
                                                            // [56:54] error_code
  output logic [tgarle_pkg::OUT_USER_W-1:0] m_axis_tuser,   // [0] kind
  output logic                              m_axis_tlast    // last_pixel
);
  import tgarle_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  tgarle_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push)
  );

  tgarle_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_push_i (q_push),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .q_head_o (q_head)
  );

  tgarle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_head_i      (q_head),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
